// ----- design/clx_pkg.sv -----
// Shared types, token codes and character tables for the C subset lexer.
`default_nettype none

package clx_pkg;

	localparam int IdentBytesDefault = 8;
	localparam int FifoDepthDefault  = 8;

	typedef enum logic [4:0] {
		KIND_LPAREN  = 5'd0,
		KIND_RPAREN  = 5'd1,
		KIND_LBRACE  = 5'd2,
		KIND_RBRACE  = 5'd3,
		KIND_SEMI    = 5'd4,
		KIND_COMMA   = 5'd5,
		KIND_ASSIGN  = 5'd6,
		KIND_PLUS    = 5'd7,
		KIND_MINUS   = 5'd8,
		KIND_SLASH   = 5'd9,
		KIND_STAR    = 5'd10,
		KIND_PERCENT = 5'd11,
		KIND_BANG    = 5'd12,
		KIND_TILDE   = 5'd13,
		KIND_INT     = 5'd14,
		KIND_RETURN  = 5'd15,
		KIND_NUMBER  = 5'd16,
		KIND_IDENT   = 5'd17,
		KIND_END     = 5'd18
	} token_kind_t;

	localparam logic [7:0] CharNul     = 8'h00;
	localparam logic [7:0] CharNewline = 8'h0A;
	localparam logic [7:0] CharSlash   = 8'h2F;
	localparam logic [7:0] CharStar    = 8'h2A;

	// Keyword spellings, first character in the lowest byte.
	localparam logic [63:0] WordReturn = 64'h0000_6E72_7574_6572;
	localparam logic [63:0] WordInt    = 64'h0000_0000_0074_6E69;

	typedef struct packed {
		logic [4:0]  kind;
		logic [31:0] num;
		logic [63:0] text;
		logic [7:0]  len;
		logic        last;
	} clx_token_t;

	// Tokens produced by one byte: count is 0, 1 or 2, tok0 goes out first.
	typedef struct packed {
		logic [1:0] count;
		clx_token_t tok0;
		clx_token_t tok1;
	} clx_push_t;

	typedef struct packed {
		logic        hit;
		token_kind_t kind;
	} clx_op_t;

	function automatic clx_op_t op_lookup(input logic [7:0] c);
		clx_op_t r;
		r.hit  = 1'b1;
		r.kind = KIND_LPAREN;
		case (c)
			8'h28: r.kind = KIND_LPAREN;
			8'h29: r.kind = KIND_RPAREN;
			8'h7B: r.kind = KIND_LBRACE;
			8'h7D: r.kind = KIND_RBRACE;
			8'h3B: r.kind = KIND_SEMI;
			8'h2C: r.kind = KIND_COMMA;
			8'h3D: r.kind = KIND_ASSIGN;
			8'h2B: r.kind = KIND_PLUS;
			8'h2D: r.kind = KIND_MINUS;
			8'h2F: r.kind = KIND_SLASH;
			8'h2A: r.kind = KIND_STAR;
			8'h25: r.kind = KIND_PERCENT;
			8'h21: r.kind = KIND_BANG;
			8'h7E: r.kind = KIND_TILDE;
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- design/clx_core.sv -----
// Scanner state and the combinational token decision per source byte.
`default_nettype none

module clx_core
	import clx_pkg::*;
#(
	parameter int IDENT_BYTES = IdentBytesDefault
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [7:0] in_byte,
	output clx_push_t       push
);

	localparam int StoredBytes = (IDENT_BYTES < 8) ? IDENT_BYTES : 8;

	typedef enum logic [2:0] {
		MODE_NORMAL = 3'd0,
		MODE_IDENT  = 3'd1,
		MODE_NUMBER = 3'd2,
		MODE_SLASH  = 3'd3,
		MODE_LINE   = 3'd4,
		MODE_BLOCK  = 3'd5,
		MODE_STAR   = 3'd6
	} mode_t;

	mode_t       mode_q, mode_d;
	logic [31:0] acc_q, acc_d;
	logic [63:0] buf_q, buf_d;
	logic [7:0]  cnt_q, cnt_d;

	clx_token_t tok_a, tok_b;
	logic       has_a, has_b, go_normal;
	logic       is_digit, is_letter;
	clx_op_t    op;

	assign is_digit = (in_byte >= 8'h30) && (in_byte <= 8'h39);
	assign is_letter = ((in_byte >= 8'h61) && (in_byte <= 8'h7A)) ||
		((in_byte >= 8'h41) && (in_byte <= 8'h5A));
	assign op = op_lookup(in_byte);

	always_comb begin
		mode_d    = mode_q;
		acc_d     = acc_q;
		buf_d     = buf_q;
		cnt_d     = cnt_q;
		tok_a     = '0;
		tok_b     = '0;
		has_a     = 1'b0;
		has_b     = 1'b0;
		go_normal = 1'b0;
		if (in_valid) begin
			case (mode_q)
				MODE_IDENT: begin
					if (is_letter || is_digit) begin
						if (cnt_q < 8'(StoredBytes))
							buf_d[{cnt_q[2:0], 3'b000} +: 8] = in_byte;
						if (cnt_q != 8'hFF)
							cnt_d = cnt_q + 8'd1;
					end else begin
						has_a = 1'b1;
						if (cnt_q == 8'd6 && buf_q == WordReturn) begin
							tok_a.kind = KIND_RETURN;
						end else if (cnt_q == 8'd3 && buf_q == WordInt) begin
							tok_a.kind = KIND_INT;
						end else begin
							tok_a.kind = KIND_IDENT;
							tok_a.text = buf_q;
							tok_a.len  = cnt_q;
						end
						buf_d     = '0;
						cnt_d     = '0;
						go_normal = 1'b1;
					end
				end
				MODE_NUMBER: begin
					if (is_digit) begin
						// Times ten as two shifted copies, plus the new digit.
						acc_d = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0} +
							{28'd0, in_byte[3:0]};
					end else begin
						has_a      = 1'b1;
						tok_a.kind = KIND_NUMBER;
						tok_a.num  = acc_q;
						acc_d      = '0;
						go_normal  = 1'b1;
					end
				end
				MODE_SLASH: begin
					if (in_byte == CharSlash) begin
						mode_d = MODE_LINE;
					end else if (in_byte == CharStar) begin
						mode_d = MODE_BLOCK;
					end else begin
						has_a      = 1'b1;
						tok_a.kind = KIND_SLASH;
						go_normal  = 1'b1;
					end
				end
				MODE_LINE, MODE_BLOCK, MODE_STAR: begin
					if (in_byte == CharNul) begin
						has_b      = 1'b1;
						tok_b.kind = KIND_END;
						mode_d     = MODE_NORMAL;
						acc_d      = '0;
						buf_d      = '0;
						cnt_d      = '0;
					end else if (mode_q == MODE_LINE) begin
						if (in_byte == CharNewline)
							mode_d = MODE_NORMAL;
					end else if (mode_q == MODE_BLOCK) begin
						if (in_byte == CharStar)
							mode_d = MODE_STAR;
					end else begin
						if (in_byte == CharSlash)
							mode_d = MODE_NORMAL;
						else if (in_byte != CharStar)
							mode_d = MODE_BLOCK;
					end
				end
				default: go_normal = 1'b1;
			endcase

			// Plain scanning of the byte, also after a pending token closed.
			if (go_normal) begin
				mode_d = MODE_NORMAL;
				if (in_byte == CharNul) begin
					has_b      = 1'b1;
					tok_b.kind = KIND_END;
					acc_d      = '0;
					buf_d      = '0;
					cnt_d      = '0;
				end else if (in_byte == CharSlash) begin
					mode_d = MODE_SLASH;
				end else if (op.hit) begin
					has_b      = 1'b1;
					tok_b.kind = op.kind;
				end else if (is_letter) begin
					buf_d  = {56'd0, in_byte};
					cnt_d  = 8'd1;
					mode_d = MODE_IDENT;
				end else if (is_digit) begin
					acc_d  = {28'd0, in_byte[3:0]};
					mode_d = MODE_NUMBER;
				end
			end
		end

		push.count     = {has_a & has_b, has_a ^ has_b};
		push.tok0      = has_a ? tok_a : tok_b;
		push.tok0.last = !(has_a && has_b);
		push.tok1      = tok_b;
		push.tok1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			acc_q  <= '0;
			buf_q  <= '0;
			cnt_q  <= '0;
		end else begin
			mode_q <= mode_d;
			acc_q  <= acc_d;
			buf_q  <= buf_d;
			cnt_q  <= cnt_d;
		end
	end

`ifndef SYNTHESIS
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_byte == CharNul |=>
		mode_q == MODE_NORMAL && acc_q == '0 && buf_q == '0 && cnt_q == '0)
		else $error("zero byte did not return the scanner to its reset state");
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.count == 2'd2 |-> push.tok1.last && !push.tok0.last &&
		push.tok1.kind != KIND_NUMBER && push.tok1.kind != KIND_IDENT)
		else $error("two-token word has wrong ordering or last flags");
	a_comment_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_byte != CharNul &&
		(mode_q == MODE_LINE || mode_q == MODE_BLOCK || mode_q == MODE_STAR)
		|-> push.count == 2'd0)
		else $error("token produced inside a comment");
`endif

endmodule

`default_nettype wire

// ----- design/clx_fifo.sv -----
// Token queue: takes up to two tokens per cycle, gives one on out_ready.
`default_nettype none

module clx_fifo
	import clx_pkg::*;
#(
	parameter int DEPTH = FifoDepthDefault
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  clx_push_t  push,
	output logic       room,
	output logic       out_valid,
	input  wire logic  out_ready,
	output clx_token_t out_tok
);

	localparam int AW = $clog2(DEPTH);

	clx_token_t      entries_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [AW:0]     count_q;
	logic            pop;
	logic [AW-1:0]   wr_ptr_next;

	assign pop         = out_valid && out_ready;
	assign out_valid   = (count_q != '0);
	assign out_tok     = entries_q[rd_ptr_q];
	assign wr_ptr_next = wr_ptr_q + AW'(1);
	// Space for the word in the input register and one more behind it.
	assign room        = (count_q <= (AW + 1)'(DEPTH - 4));

	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			entries_q[wr_ptr_q] <= push.tok0;
		if (push.count == 2'd2)
			entries_q[wr_ptr_next] <= push.tok1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + AW'(push.count);
			if (pop)
				rd_ptr_q <= rd_ptr_q + AW'(1);
			count_q <= count_q + (AW + 1)'(push.count) - (AW + 1)'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(AW + 2)'(count_q) + (AW + 2)'(push.count) <= (AW + 2)'(DEPTH))
		else $error("token queue overflow");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (AW + 1)'(DEPTH))
		else $error("token queue count out of range");
`endif

endmodule

`default_nettype wire

// ----- design/c_subset_lexer.sv -----
// Top level of the C subset lexer: input register, scanner and token queue.
// The input register holds each accepted byte for the scanner; its tokens queue for m_tdata.
// Throughput: one byte per cycle; the queue drains one token per cycle while m_tready is
// high and absorbs two-token bytes; tready drops while more than FIFO_DEPTH - 4 tokens wait.
// Reset: arst_n clears the scanner to normal mode, empties the queue and the input register.
`default_nettype none

module c_subset_lexer
	import clx_pkg::*;
#(
	parameter int IDENT_BYTES = IdentBytesDefault,  // identifier bytes, 6 to 32; at most 8 stored
	parameter int FIFO_DEPTH  = FifoDepthDefault    // token queue entries, power of two, 8 up
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// Source byte stream.
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,   // [7:0] char_byte
	// Token stream.
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [111:0]      m_tdata,   // [4:0] token_kind, [36:5] number_value,
	                                     // [100:37] ident_text, [108:101] ident_length, zero pad
	output logic              m_tlast    // last_of_run: final token caused by one byte
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	clx_push_t  push;
	clx_token_t head;
	logic       room;

	// The input register takes a word whenever the queue has room for both
	// the word already held here and the new one, two tokens each at most.
	assign s_tready = room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_tvalid && s_tready;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			byte_s1 <= s_tdata;
	end

	// The scanner looks at the registered byte and decides all tokens it
	// causes in the same cycle, so its mode is current for the next byte.
	clx_core #(
		.IDENT_BYTES(IDENT_BYTES)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(valid_s1),
		.in_byte (byte_s1),
		.push    (push)
	);

	// Tokens wait here until the sink takes them; the head entry is the
	// output register.
	clx_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_tok  (head)
	);

	assign m_tdata = {3'b000, head.len, head.text, head.num, head.kind};
	assign m_tlast = head.last;

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the C subset lexer: byte stream in, checked token stream out.

module tb_top;
	import clx_pkg::*;

	// Scanner modes of the token predictor.
	typedef enum logic [2:0] {
		SCAN_NORMAL,
		SCAN_IDENT,
		SCAN_NUMBER,
		SCAN_SLASH,
		SCAN_LINE,
		SCAN_BLOCK,
		SCAN_STAR
	} scan_mode_t;

	localparam int StoredChars = (IdentBytesDefault < 8) ? IdentBytesDefault : 8;
	// Keyword spellings with the first character in the lowest byte.
	localparam logic [63:0] TextReturn = 64'h0000_6E72_7574_6572;
	localparam logic [63:0] TextInt    = 64'h0000_0000_0074_6E69;
	localparam logic [7:0]  ByteNul    = 8'h00;
	localparam int PhaseBytes = 660;

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata  = 8'h00;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [111:0] m_tdata;
	logic         m_tlast;

	c_subset_lexer u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predictor state: a private copy of the scanner.
	scan_mode_t  lex_mode  = SCAN_NORMAL;
	logic [31:0] lex_value = '0;
	logic [63:0] lex_text  = '0;
	logic [7:0]  lex_len   = '0;

	clx_token_t  step_tokens[$];   // tokens caused by the byte being lexed
	clx_token_t  lexed_tokens[$];  // tokens the block still owes, oldest first
	logic [7:0]  source_text[$];   // bytes not yet offered to the block

	string op_chars      = "(){};,=+-/*%!~";
	string white_chars   = " \t\n\r";
	string near_words[8] = '{"in", "intx", "Int", "int9", "retur", "returns", "returN", "re"};

	int sender_idle_pct    = 0;
	int receiver_stall_pct = 0;
	bit byte_taken         = 1'b0;

	int bytes_sent     = 0;
	int tokens_checked = 0;
	int double_bytes   = 0;
	int texts_ended    = 0;
	int bad_tokens     = 0;
	bit [18:0] kinds_seen = '0;

	task automatic flag_token(input string what);
		$display("%0t: token mismatch: %s", $time, what);
		bad_tokens++;
	endtask

	function automatic bit is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic void add_token(input token_kind_t kind, input logic [31:0] value = '0,
			input logic [63:0] text = '0, input logic [7:0] len = '0);
		clx_token_t tk;
		tk.kind = kind;
		tk.num  = value;
		tk.text = text;
		tk.len  = len;
		tk.last = 1'b0;
		step_tokens.push_back(tk);
	endfunction

	// A zero byte closes the text and puts the scanner back to its reset state.
	function automatic void end_text();
		add_token(KIND_END);
		lex_mode  = SCAN_NORMAL;
		lex_value = '0;
		lex_text  = '0;
		lex_len   = '0;
	endfunction

	// Scan one byte with no token pending.
	function automatic void scan_plain(input logic [7:0] c);
		token_kind_t op;
		bit          is_op;
		is_op    = 1'b1;
		op       = KIND_LPAREN;
		lex_mode = SCAN_NORMAL;
		case (c)
			"(": op = KIND_LPAREN;
			")": op = KIND_RPAREN;
			"{": op = KIND_LBRACE;
			"}": op = KIND_RBRACE;
			";": op = KIND_SEMI;
			",": op = KIND_COMMA;
			"=": op = KIND_ASSIGN;
			"+": op = KIND_PLUS;
			"-": op = KIND_MINUS;
			"*": op = KIND_STAR;
			"%": op = KIND_PERCENT;
			"!": op = KIND_BANG;
			"~": op = KIND_TILDE;
			default: is_op = 1'b0;
		endcase
		if (c == ByteNul) begin
			end_text();
		end else if (c == "/") begin
			lex_mode = SCAN_SLASH;
		end else if (is_op) begin
			add_token(op);
		end else if (is_letter(c)) begin
			lex_text = {56'h0, c};
			lex_len  = 8'd1;
			lex_mode = SCAN_IDENT;
		end else if (is_digit(c)) begin
			lex_value = {24'd0, c - "0"};
			lex_mode  = SCAN_NUMBER;
		end
	endfunction

	// Works out the tokens one accepted byte causes and queues them.
	function automatic void lex_byte(input logic [7:0] c);
		step_tokens.delete();
		case (lex_mode)
			SCAN_IDENT: begin
				if (is_letter(c) || is_digit(c)) begin
					if (lex_len < StoredChars) lex_text[lex_len * 8 +: 8] = c;
					if (lex_len != 8'd255) lex_len++;
				end else begin
					// Keywords need the exact length as well as the stored characters.
					if (lex_len == 8'd6 && lex_text == TextReturn) add_token(KIND_RETURN);
					else if (lex_len == 8'd3 && lex_text == TextInt) add_token(KIND_INT);
					else add_token(KIND_IDENT, '0, lex_text, lex_len);
					lex_text = '0;
					lex_len  = '0;
					scan_plain(c);
				end
			end
			SCAN_NUMBER: begin
				if (is_digit(c)) begin
					lex_value = lex_value * 32'd10 + {24'd0, c - "0"};
				end else begin
					add_token(KIND_NUMBER, lex_value);
					lex_value = '0;
					scan_plain(c);
				end
			end
			SCAN_SLASH: begin
				if (c == "/") lex_mode = SCAN_LINE;
				else if (c == "*") lex_mode = SCAN_BLOCK;
				else begin
					add_token(KIND_SLASH);
					scan_plain(c);
				end
			end
			SCAN_LINE: begin
				if (c == ByteNul) end_text();
				else if (c == "\n") lex_mode = SCAN_NORMAL;
			end
			SCAN_BLOCK: begin
				if (c == ByteNul) end_text();
				else if (c == "*") lex_mode = SCAN_STAR;
			end
			SCAN_STAR: begin
				if (c == ByteNul) end_text();
				else if (c == "/") lex_mode = SCAN_NORMAL;
				else if (c != "*") lex_mode = SCAN_BLOCK;
			end
			default: scan_plain(c);
		endcase
		if (step_tokens.size() != 0) step_tokens[$].last = 1'b1;
		if (step_tokens.size() == 2) double_bytes++;
		if (c == ByteNul) texts_ended++;
		foreach (step_tokens[i]) lexed_tokens.push_back(step_tokens[i]);
	endfunction

	function automatic void push_text(input string s);
		foreach (s[i]) source_text.push_back(s[i]);
	endfunction

	function automatic logic [7:0] rand_letter();
		int x;
		x = $urandom_range(51);
		return 8'((x < 26) ? "A" + x : "a" + x - 26);
	endfunction

	function automatic void push_ident(input int n);
		source_text.push_back(rand_letter());
		for (int i = 1; i < n; i++) begin
			if ($urandom_range(3) == 0) source_text.push_back(8'("0" + $urandom_range(9)));
			else source_text.push_back(rand_letter());
		end
	endfunction

	// Appends one random piece of source text. Pieces are joined with no separator,
	// so identifiers, numbers and operators often close each other.
	function automatic void add_fragment();
		int pick;
		int n;
		pick = $urandom_range(99);
		if (pick < 8) begin
			push_text($urandom_range(1) ? "int" : "return");
		end else if (pick < 12) begin
			push_text(near_words[$urandom_range(7)]);
		end else if (pick < 27) begin
			push_ident(($urandom_range(9) == 0) ? $urandom_range(12, 7) : $urandom_range(6, 1));
		end else if (pick < 39) begin
			// Ten digits and up can run past 2^32 and wrap.
			n = ($urandom_range(4) == 0) ? $urandom_range(12, 9) : $urandom_range(4, 1);
			repeat (n) source_text.push_back(8'("0" + $urandom_range(9)));
		end else if (pick < 57) begin
			source_text.push_back(op_chars[$urandom_range(13)]);
		end else if (pick < 69) begin
			source_text.push_back(white_chars[$urandom_range(3)]);
		end else if (pick < 75) begin
			push_text("//");
			repeat ($urandom_range(10)) source_text.push_back(8'($urandom_range(255, 1)));
			if ($urandom_range(9) != 0) push_text("\n");
		end else if (pick < 81) begin
			push_text("/*");
			repeat ($urandom_range(10)) begin
				n = $urandom_range(3);
				if (n == 0) push_text("*");
				else if (n == 1) push_text("/");
				else source_text.push_back(8'($urandom_range(255, 1)));
			end
			if ($urandom_range(9) != 0) push_text("*/");
		end else if (pick < 93) begin
			// Any nonzero byte, the high half among them.
			source_text.push_back(8'($urandom_range(255, 1)));
		end else if (pick < 97) begin
			push_text("/");
			source_text.push_back(ByteNul);
		end else begin
			source_text.push_back(ByteNul);
		end
	endfunction

	// Driver: offers source bytes and the token-side ready, both at the falling edge.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= receiver_stall_pct);
			if (!s_tvalid || byte_taken) begin
				if (source_text.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= source_text.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: at each rising edge, lex the accepted byte and check the accepted token word.
	always @(posedge clk) begin
		clx_token_t got;
		clx_token_t want;
		if (arst_n) begin
			byte_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				lex_byte(s_tdata);
				bytes_sent++;
			end
			if (m_tvalid && m_tready) begin
				got.kind = m_tdata[4:0];
				got.num  = m_tdata[36:5];
				got.text = m_tdata[100:37];
				got.len  = m_tdata[108:101];
				got.last = m_tlast;
				if (lexed_tokens.size() == 0) begin
					flag_token($sformatf("kind %0d arrived with no token owed", got.kind));
				end else begin
					want = lexed_tokens.pop_front();
					tokens_checked++;
					kinds_seen[want.kind] = 1'b1;
					if (got !== want || m_tdata[111:109] !== 3'b000) begin
						flag_token($sformatf(
							"kind %0d/%0d value %h/%h text %h/%h len %0d/%0d last %b/%b pad %b",
							got.kind, want.kind, got.num, want.num, got.text, want.text,
							got.len, want.len, got.last, want.last, m_tdata[111:109]));
					end
				end
			end
		end
	end

	// Stimulus: three phases with different stall patterns. Between phases the source is
	// held back until every owed token has come out.
	initial begin
		int phase;
		int n;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					sender_idle_pct    = 11;
					receiver_stall_pct = 82;
				end
				1: begin
					sender_idle_pct    = 82;
					receiver_stall_pct = 11;
				end
				default: begin
					sender_idle_pct    = 0;
					receiver_stall_pct = 0;
				end
			endcase
			if (phase == 0) begin
				// Every operator, with a slash closed by another operator; a number closed
				// by a slash that opens a block comment holding slash-star and star-star-slash;
				// an identifier closed by a newline; a line comment with a high byte, ended
				// by a zero byte.
				push_text("(){};,=+-/%*!~");
				push_text("9/*/**/x\n//");
				source_text.push_back(8'hFF);
				source_text.push_back(ByteNul);
			end
			// One identifier per phase long enough for the length to saturate.
			push_ident($urandom_range(270, 256));
			source_text.push_back(" ");
			while (source_text.size() < PhaseBytes) add_fragment();
			if (phase == 2) source_text.push_back(ByteNul);
			do @(posedge clk); while (source_text.size() != 0 || s_tvalid);
			for (n = 0; n < 20000 && lexed_tokens.size() != 0; n++) @(posedge clk);
		end
		// Let any stray extra token surface before closing out.
		repeat (32) @(posedge clk);
		if (lexed_tokens.size() != 0) begin
			flag_token($sformatf("%0d tokens never arrived", lexed_tokens.size()));
		end
		$display("Lexed %0d source bytes over %0d texts under three stall patterns; %0d tokens checked.",
			bytes_sent, texts_ended, tokens_checked);
		$display("%0d bytes gave two tokens; %0d of 19 token kinds were seen; %0d mismatches.",
			double_bytes, $countones(kinds_seen), bad_tokens);
		if (bad_tokens == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- c_subset_lexer.f -----
design/clx_pkg.sv
design/clx_core.sv
design/clx_fifo.sv
design/c_subset_lexer.sv
dv/tb_top.sv
